@@ rtl/core/irt_pkg.sv @@
package irt_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_SEND = 2'd0,
    CMD_ACK  = 2'd1,
    CMD_DROP = 2'd2,
    CMD_TICK = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_TRAP   = 3'd0,
    KIND_INFORM = 3'd1,
    KIND_RESEND = 3'd2,
    KIND_FAIL   = 3'd3,
    KIND_DONE   = 3'd4,
    KIND_FULL   = 3'd5
  } kind_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] request_id;
    logic [7:0]  trap_id;
    logic [31:0] dest_ip;
    logic        is_inform;
    logic        build_ok;
    logic        replace_queued;
    logic [7:0]  retry_count;
    logic [23:0] timeout_ms;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       out_trap_id;
    logic [31:0]      out_ip;
    logic [31:0]      out_request_id;
    logic [CNT_W-1:0] pending_count;
    logic             last;
  } result_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] request;
    logic [7:0]  source;
    logic [31:0] address;
    logic [7:0]  retries;
    logic [23:0] wait_ms;
    logic [31:0] sent;
  } entry_t;

endpackage

@@ rtl/core/irt_cell.sv @@
module irt_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  irt_pkg::entry_t entry_i,
  output irt_pkg::entry_t entry_o
);
  import irt_pkg::*;

  logic   valid_q;
  entry_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= entry_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= entry_i;
    end
  end

  always_comb begin
    entry_o       = data_q;
    entry_o.valid = valid_q;
  end

endmodule

@@ rtl/core/inform_retransmit_table.sv @@
// Table of up to TABLE_DEPTH outstanding informs, held in a ring of cells
// that rotates one slot per cycle while a command is processed, past a
// single processing point. Every command takes one full rotation, then the
// EMIT state forms its final result in a register from which the final beat
// is presented. A tick first takes an extra rotation to count the entries
// that survive. The next item can be accepted in the cycle after the final
// beat. Resends appear on res_o in slot order, registered from the last
// rotation, each for one cycle, and the final beat carries last. Results
// cannot be held off; busy stays high until the final beat is out.
module inform_retransmit_table (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  irt_pkg::item_t   item_i,
  output irt_pkg::result_t res_o,
  output logic             res_valid_o
);
  import irt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e           state_q;
  item_t            item_q;
  logic [IDX_W-1:0] step_q;
  logic [CNT_W-1:0] cnt_q;
  logic             stored_q;
  result_t          res_q;
  logic             res_valid_q;

  entry_t ring_q  [TABLE_DEPTH];
  entry_t ring_in [TABLE_DEPTH];
  entry_t head, head_new;
  logic   shift;
  logic   store_now, emit_now, survive, timed_out;
  logic   last_step;
  logic [31:0] elapsed;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign ring_in[i] = head_new;
    end else begin : g_mid
      assign ring_in[i] = ring_q[i+1];
    end
    irt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .entry_i (ring_in[i]),
      .entry_o (ring_q[i])
    );
  end

  assign head      = ring_q[0];
  assign shift     = (state_q == ST_COUNT) || (state_q == ST_SCAN);
  assign last_step = (step_q == IDX_W'(TABLE_DEPTH - 1));
  assign elapsed   = item_q.now_ms - head.sent;
  assign timed_out = head.valid && (elapsed > {8'd0, head.wait_ms});
  assign survive   = head.valid && !(timed_out && (head.retries == 8'd0));

  always_comb begin
    head_new  = head;
    store_now = 1'b0;
    emit_now  = 1'b0;
    if (state_q == ST_SCAN) begin
      unique case (item_q.cmd)
        CMD_SEND: begin
          if (item_q.build_ok) begin
            if (item_q.replace_queued && head.valid && head.source == item_q.trap_id) begin
              head_new.valid = 1'b0;
            end
            if (item_q.is_inform && !stored_q && !head_new.valid) begin
              store_now        = 1'b1;
              head_new.valid   = 1'b1;
              head_new.request = item_q.request_id;
              head_new.source  = item_q.trap_id;
              head_new.address = item_q.dest_ip;
              head_new.retries = item_q.retry_count;
              head_new.wait_ms = item_q.timeout_ms;
              head_new.sent    = item_q.now_ms;
            end
          end
        end
        CMD_ACK: begin
          if (head.valid && head.request == item_q.request_id) head_new.valid = 1'b0;
        end
        CMD_DROP: begin
          if (head.valid && head.source == item_q.trap_id) head_new.valid = 1'b0;
        end
        CMD_TICK: begin
          if (timed_out) begin
            if (head.retries == 8'd0) begin
              head_new.valid = 1'b0;
            end else begin
              emit_now         = 1'b1;
              head_new.sent    = item_q.now_ms;
              head_new.retries = head.retries - 8'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      stored_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start && !busy) begin
            step_q   <= '0;
            cnt_q    <= '0;
            stored_q <= 1'b0;
            state_q  <= (item_i.cmd == CMD_TICK) ? ST_COUNT : ST_SCAN;
          end
        end
        ST_COUNT: begin
          if (survive) cnt_q <= cnt_q + CNT_W'(1);
          step_q <= last_step ? '0 : step_q + IDX_W'(1);
          if (last_step) state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          // A tick already knows its final count from the first rotation.
          if (item_q.cmd != CMD_TICK && head_new.valid) cnt_q <= cnt_q + CNT_W'(1);
          if (store_now) stored_q <= 1'b1;
          res_valid_q <= emit_now;
          step_q <= last_step ? '0 : step_q + IDX_W'(1);
          if (last_step) state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          res_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start && !busy) begin
      item_q <= item_i;
    end
    if (state_q == ST_SCAN) begin
      res_q.kind           <= KIND_RESEND;
      res_q.out_trap_id    <= head.source;
      res_q.out_ip         <= head.address;
      res_q.out_request_id <= head.request;
      res_q.pending_count  <= cnt_q;
      res_q.last           <= 1'b0;
    end else if (state_q == ST_EMIT) begin
      res_q.out_trap_id    <= item_q.trap_id;
      res_q.out_ip         <= item_q.dest_ip;
      res_q.out_request_id <= item_q.request_id;
      res_q.pending_count  <= cnt_q;
      res_q.last           <= 1'b1;
      if (item_q.cmd != CMD_SEND) begin
        res_q.kind <= KIND_DONE;
      end else if (!item_q.build_ok) begin
        res_q.kind <= KIND_FAIL;
      end else if (!item_q.is_inform) begin
        res_q.kind <= KIND_TRAP;
      end else if (stored_q) begin
        res_q.kind <= KIND_INFORM;
      end else begin
        res_q.kind <= KIND_FULL;
      end
      if (item_q.cmd != CMD_SEND || !item_q.build_ok) begin
        res_q.out_trap_id    <= '0;
        res_q.out_ip         <= '0;
        res_q.out_request_id <= '0;
      end
    end
  end

  assign busy        = (state_q != ST_IDLE) || res_valid_q;
  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

@@ rtl/core/irt_checker.sv @@
module irt_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input irt_pkg::result_t res_o,
  input logic             res_valid_o
);
  import irt_pkg::*;

  a_beat_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy) else $error("result beat outside an item");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |=> !busy) else $error("busy after final beat");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted item not busy");

  a_mid_resend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> res_o.kind == KIND_RESEND)
    else $error("non-final beat is not a resend");

endmodule

bind inform_retransmit_table irt_checker u_irt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_o       (res_o),
  .res_valid_o (res_valid_o)
);

@@ sim/testbench.sv @@
module testbench;
  import irt_pkg::*;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  item_t   item_i = '0;
  result_t res_o;
  logic    res_valid_o;

  inform_retransmit_table DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .item_i(item_i), .res_o(res_o), .res_valid_o(res_valid_o)
  );

  always #6 clk_i = ~clk_i;

  // Predictor copy of the table.
  logic        tbl_valid [TABLE_DEPTH];
  logic [31:0] tbl_req   [TABLE_DEPTH];
  logic [7:0]  tbl_src   [TABLE_DEPTH];
  logic [31:0] tbl_ip    [TABLE_DEPTH];
  logic [7:0]  tbl_retry [TABLE_DEPTH];
  logic [23:0] tbl_wait  [TABLE_DEPTH];
  logic [31:0] tbl_sent  [TABLE_DEPTH];

  item_t   pending_items [$];
  result_t expected_results [$];
  int      errors = 0;
  int      beats_seen = 0;
  int      resends_seen = 0;
  int      items_seen = 0;
  bit      stim_done = 1'b0;
  logic [31:0] clock_ms = 32'd1000;
  logic [31:0] used_req [$];

  function automatic result_t mk(kind_e k, logic [7:0] s, logic [31:0] ip,
                                 logic [31:0] rq);
    result_t r;
    r = '0;
    r.kind = k;
    r.out_trap_id = s;
    r.out_ip = ip;
    r.out_request_id = rq;
    return r;
  endfunction

  task automatic predict_table(input item_t it);
    result_t outs [$];
    int      fs;
    int      cnt;
    outs = {};
    fs = -1;
    cnt = 0;
    case (it.cmd)
      CMD_SEND: begin
        if (!it.build_ok) begin
          outs = {outs, mk(KIND_FAIL, 0, 0, 0)};
        end else begin
          if (it.replace_queued)
            for (int i = 0; i < TABLE_DEPTH; i++)
              if (tbl_valid[i] && tbl_src[i] == it.trap_id) tbl_valid[i] = 1'b0;
          if (!it.is_inform) begin
            outs = {outs, mk(KIND_TRAP, it.trap_id, it.dest_ip, it.request_id)};
          end else begin
            for (int i = 0; i < TABLE_DEPTH; i++)
              if (fs < 0 && !tbl_valid[i]) fs = i;
            if (fs < 0) begin
              outs = {outs, mk(KIND_FULL, it.trap_id, it.dest_ip, it.request_id)};
            end else begin
              tbl_valid[fs] = 1'b1;
              tbl_req[fs] = it.request_id;
              tbl_src[fs] = it.trap_id;
              tbl_ip[fs] = it.dest_ip;
              tbl_retry[fs] = it.retry_count;
              tbl_wait[fs] = it.timeout_ms;
              tbl_sent[fs] = it.now_ms;
              outs = {outs, mk(KIND_INFORM, it.trap_id, it.dest_ip, it.request_id)};
            end
          end
        end
      end
      CMD_ACK: begin
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (tbl_valid[i] && tbl_req[i] == it.request_id) tbl_valid[i] = 1'b0;
        outs = {outs, mk(KIND_DONE, 0, 0, 0)};
      end
      CMD_DROP: begin
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (tbl_valid[i] && tbl_src[i] == it.trap_id) tbl_valid[i] = 1'b0;
        outs = {outs, mk(KIND_DONE, 0, 0, 0)};
      end
      default: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (tbl_valid[i] && (it.now_ms - tbl_sent[i]) > {8'd0, tbl_wait[i]}) begin
            if (tbl_retry[i] == 8'd0) begin
              tbl_valid[i] = 1'b0;
            end else begin
              outs = {outs, mk(KIND_RESEND, tbl_src[i], tbl_ip[i], tbl_req[i])};
              tbl_sent[i] = it.now_ms;
              tbl_retry[i] = tbl_retry[i] - 8'd1;
            end
          end
        end
        outs = {outs, mk(KIND_DONE, 0, 0, 0)};
      end
    endcase
    for (int i = 0; i < TABLE_DEPTH; i++) cnt += tbl_valid[i];
    foreach (outs[j]) begin
      outs[j].pending_count = cnt[CNT_W-1:0];
      outs[j].last = (j == outs.size() - 1);
      expected_results = {expected_results, outs[j]};
    end
  endtask

  // Driver: bursts of back-to-back items separated by random gaps.
  logic busy_at_edge = 1'b1;
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy_at_edge) begin
        // the previous beat was taken at the last rising edge
      end
      if (!(start && !busy_at_edge) && start) begin
        // still waiting for the block; hold the item
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_items.size() > 0) begin
        item_i <= pending_items.pop_front();
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 6);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Acceptance and result monitor, both sampled at the rising edge.
  always @(posedge clk_i) begin
    busy_at_edge <= busy;
    if (rst_ni && start && !busy) begin
      items_seen++;
      predict_table(item_i);
    end
    if (rst_ni && res_valid_o) begin
      result_t e;
      beats_seen++;
      if (res_o.kind == KIND_RESEND) resends_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result beat kind=%0d", res_o.kind);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (res_o.kind !== e.kind) begin
          $error("kind: expected %0d actual %0d", e.kind, res_o.kind); errors++;
        end
        if (res_o.out_trap_id !== e.out_trap_id) begin
          $error("out_trap_id: expected %0h actual %0h", e.out_trap_id,
                 res_o.out_trap_id); errors++;
        end
        if (res_o.out_ip !== e.out_ip) begin
          $error("out_ip: expected %0h actual %0h", e.out_ip, res_o.out_ip); errors++;
        end
        if (res_o.out_request_id !== e.out_request_id) begin
          $error("out_request_id: expected %0h actual %0h", e.out_request_id,
                 res_o.out_request_id); errors++;
        end
        if (res_o.pending_count !== e.pending_count) begin
          $error("pending_count: expected %0d actual %0d", e.pending_count,
                 res_o.pending_count); errors++;
        end
        if (res_o.last !== e.last) begin
          $error("last: expected %0b actual %0b", e.last, res_o.last); errors++;
        end
      end
    end
  end

  function automatic item_t rand_item();
    item_t it;
    it.cmd = cmd_e'($urandom_range(0, 3));
    it.request_id = $urandom;
    it.trap_id = 8'($urandom);
    it.dest_ip = $urandom;
    it.is_inform = 1'($urandom);
    it.build_ok = 1'($urandom);
    it.replace_queued = 1'($urandom);
    it.retry_count = 8'($urandom);
    it.timeout_ms = 24'($urandom);
    it.now_ms = $urandom;
    return it;
  endfunction

  // Well-formed traffic: few sources, short timeouts, time that moves forward.
  function automatic item_t flow_item();
    item_t it;
    int    sel;
    it = rand_item();
    sel = $urandom_range(0, 99);
    clock_ms = clock_ms + $urandom_range(0, 60);
    it.now_ms = clock_ms;
    it.trap_id = 8'($urandom_range(0, 5));
    it.timeout_ms = 24'($urandom_range(0, 80));
    it.retry_count = 8'($urandom_range(0, 3));
    if (sel < 45) begin
      it.cmd = CMD_SEND;
      it.is_inform = ($urandom_range(0, 4) != 0);
      it.build_ok = ($urandom_range(0, 9) != 0);
      it.replace_queued = ($urandom_range(0, 5) == 0);
      it.request_id = $urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : $urandom;
      used_req = {used_req, it.request_id};
    end else if (sel < 60) begin
      it.cmd = CMD_ACK;
      if (used_req.size() > 0 && $urandom_range(0, 3) != 0)
        it.request_id = used_req[$urandom_range(0, used_req.size() - 1)];
    end else if (sel < 65) begin
      it.cmd = CMD_DROP;
    end else if (sel < 95) begin
      it.cmd = CMD_TICK;
    end
    return it;
  endfunction

  initial begin
    item_t it;
    for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
    // Directed part: extremes, a table overflow, build failure, retries at zero.
    it = '0;
    it.cmd = CMD_SEND; it.build_ok = 1'b0; it.is_inform = 1'b1;
    pending_items = {pending_items, it};
    for (int i = 0; i < 17; i++) begin
      it = '0;
      it.cmd = CMD_SEND; it.build_ok = 1'b1; it.is_inform = 1'b1;
      it.trap_id = (i == 0) ? 8'hFF : i[7:0];
      it.request_id = (i < 2) ? 32'hFFFF_FFFF : i;
      it.dest_ip = ~i;
      it.retry_count = (i == 1) ? 8'hFF : (i == 2 ? 8'd1 : 8'd0);
      it.timeout_ms = (i == 3) ? 24'hFF_FFFF : 24'd10;
      it.now_ms = 32'hFFFF_FFF0;
      pending_items = {pending_items, it};
    end
    it = '0; it.cmd = CMD_TICK; it.now_ms = 32'h0000_0010;
    pending_items = {pending_items, it};
    pending_items = {pending_items, it};
    it.now_ms = 32'h0000_0030;
    pending_items = {pending_items, it};
    it = '0; it.cmd = CMD_ACK; it.request_id = 32'hFFFF_FFFF;
    pending_items = {pending_items, it};
    it = '0; it.cmd = CMD_DROP; it.trap_id = 8'd5;
    pending_items = {pending_items, it};
    it = '0; it.cmd = CMD_SEND; it.build_ok = 1'b1; it.replace_queued = 1'b1;
    it.trap_id = 8'd6; it.request_id = 32'hA5A5_5A5A; it.dest_ip = 32'hFFFF_FFFF;
    pending_items = {pending_items, it};
    it = '0; it.cmd = CMD_DROP; it.trap_id = 8'hFF;
    pending_items = {pending_items, it};
    for (int i = 0; i < 400; i++)
      pending_items = {pending_items,
                       (($urandom_range(0, 9) == 0) ? rand_item() : flow_item())};
    it = '0; it.cmd = CMD_TICK; it.now_ms = clock_ms + 32'h0100_0000;
    pending_items = {pending_items, it};
    pending_items = {pending_items, it};
    wait (rst_ni);
    wait (pending_items.size() == 0 && !start);
    wait (expected_results.size() == 0);
    repeat (2 * TABLE_DEPTH + 10) @(posedge clk_i);
    $display("Checked %0d result beats, %0d of them resends, over %0d commands.",
             beats_seen, resends_seen, items_seen);
    if (errors == 0 && expected_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #3000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
